// File: rtl/cfd_pkg.sv
// cfd_pkg: shared types, codes and sizing constants for the cobs frame decoder
// used by cfd_front, cfd_queue, cfd_back and cobs_frame_decoder_unit
package cfd_pkg;

    localparam int MAX_FRAME_DEF = 512;
    localparam int Q_DEPTH       = 4;
    localparam int LEN_W         = 10;

    // frame status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERRUN  = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    // register index codes (byte address bit 2)
    localparam logic REG_IDX_ENABLE = 1'b0;
    localparam logic REG_IDX_DELIM  = 1'b1;

    typedef struct packed {
        logic       enable;
        logic [7:0] delim;
    } t_cfg;

    typedef struct packed {
        logic             has_byte;
        logic [7:0]       out_byte;
        logic             frame_end;
        t_status          frame_status;
        logic [LEN_W-1:0] frame_length;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// File: rtl/cfd_front.sv
// cfd_front: accepts received bytes, tracks framing and cobs group state,
// and pushes one result per byte that yields one; depends on cfd_pkg
module cfd_front
    import cfd_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_line_idle,
    input  t_cfg       i_cfg,
    input  t_qstat     i_qstat,
    output logic       o_push,
    output t_result    o_res
);

    localparam int DW = $clog2(MAX_FRAME + 2);
    localparam int RW = $clog2(2 * MAX_FRAME + 2);
    localparam logic [DW-1:0] DC_MAX  = DW'(MAX_FRAME);
    localparam logic [DW-1:0] DC_OVF  = DW'(MAX_FRAME + 1);
    localparam logic [RW-1:0] RC_LIM  = RW'(2 * MAX_FRAME);

    logic          r_in_frame, n_in_frame;
    logic [7:0]    r_group, n_group;
    logic          r_pzero, n_pzero;
    logic [RW-1:0] r_rcnt, n_rcnt;
    logic [DW-1:0] r_dcnt, n_dcnt;

    logic    w_has;
    t_result w_res;
    logic    w_accept;

    assign o_ready  = !i_qstat.full;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        logic [7:0] code;
        logic       slot;
        code       = (i_rx_byte == 8'd0) ? 8'd1 : i_rx_byte;
        slot       = 1'b0;
        n_in_frame = r_in_frame;
        n_group    = r_group;
        n_pzero    = r_pzero;
        n_rcnt     = r_rcnt;
        n_dcnt     = r_dcnt;
        w_has      = 1'b0;
        w_res      = '0;
        if (i_line_idle || i_rx_byte == i_cfg.delim) begin
            // frame end; an idle line with no open frame is silent
            if (!(i_line_idle && !r_in_frame)) begin
                w_has           = 1'b1;
                w_res.frame_end = 1'b1;
                if (r_dcnt > DC_MAX) begin
                    w_res.frame_status = ST_TOO_LONG;
                end else if (r_group != 8'd0) begin
                    w_res.frame_status = ST_OVERRUN;
                end else begin
                    w_res.frame_status = ST_OK;
                    w_res.frame_length = LEN_W'(r_dcnt);
                end
                n_in_frame = 1'b0;
                n_group    = '0;
                n_pzero    = 1'b0;
                n_rcnt     = '0;
                n_dcnt     = '0;
            end
        end else begin
            n_in_frame = 1'b1;
            if (r_rcnt <= RC_LIM) begin
                n_rcnt = r_rcnt + 1'b1;
            end
            if (n_rcnt > RC_LIM) begin
                n_dcnt = DC_OVF;
            end
            if (n_dcnt <= DC_MAX) begin
                if (!i_cfg.enable || r_group != 8'd0) begin
                    // data byte, passed or owed by the current group
                    if (r_group != 8'd0 && i_cfg.enable) begin
                        n_group = r_group - 8'd1;
                    end
                    slot           = 1'b1;
                    w_res.out_byte = i_rx_byte;
                end else begin
                    // code byte: emits the zero owed by the previous group
                    n_group = code - 8'd1;
                    n_pzero = (code != 8'hFF);
                    slot    = r_pzero;
                end
                if (slot) begin
                    if (n_dcnt >= DC_MAX) begin
                        n_dcnt = DC_OVF;
                    end else begin
                        n_dcnt         = n_dcnt + 1'b1;
                        w_has          = 1'b1;
                        w_res.has_byte = 1'b1;
                    end
                end
            end
        end
    end

    assign o_push = w_accept && w_has;
    assign o_res  = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_group    <= '0;
            r_pzero    <= 1'b0;
            r_rcnt     <= '0;
            r_dcnt     <= '0;
        end else if (w_accept) begin
            r_in_frame <= n_in_frame;
            r_group    <= n_group;
            r_pzero    <= n_pzero;
            r_rcnt     <= n_rcnt;
            r_dcnt     <= n_dcnt;
        end
    end

endmodule

// File: rtl/cfd_queue.sv
// cfd_queue: short result queue between front and back
// depends on cfd_pkg for the result type and depth
module cfd_queue
    import cfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_wdata,
    input  logic    i_pop,
    output t_result o_rdata,
    output t_qstat  o_stat
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);
    localparam logic [PW-1:0] P_LAST = PW'(Q_DEPTH - 1);
    localparam logic [CW-1:0] C_FULL = CW'(Q_DEPTH);

    t_result       r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_rdata      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == C_FULL);
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == P_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == P_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/cfd_back.sv
// cfd_back: output register stage, pulls results from the queue and drives
// the master stream; depends on cfd_pkg
module cfd_back
    import cfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_qstat  i_qstat,
    input  t_result i_rdata,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_pop   = !i_qstat.empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_rdata;
        end
    end

endmodule

// File: rtl/cobs_frame_decoder_unit.sv
// cobs_frame_decoder_unit: input transfers reach the master stream via the
// queue and output register; one input transfer per cycle while the queue is
// not full, set by front state update; the 4-entry queue and output register
// let input and output stall independently. synchronous active-low reset clears
// frame state, queue and output valid; registers reset to decode on, delimiter 0
module cobs_frame_decoder_unit
    import cfd_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // received byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // line_idle
    // decoded result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [9:8] frame_status,
                                        // [19:10] frame_length, [23:20] zero
    output logic        m_axis_tuser,   // has_byte
    output logic        m_axis_tlast    // frame_end
);

    t_cfg    r_cfg;
    t_qstat  w_qstat;
    t_result w_push_res, w_pop_res, w_out_res;
    logic    w_push, w_pop;
    logic    w_wr;

    // configuration registers, written at the access phase of an apb transfer
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable <= 1'b1;
            r_cfg.delim  <= 8'd0;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_IDX_ENABLE: r_cfg.enable <= pwdata[0];
                REG_IDX_DELIM:  r_cfg.delim  <= pwdata[7:0];
                default:        r_cfg        <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_IDX_ENABLE: prdata = {31'd0, r_cfg.enable};
            REG_IDX_DELIM:  prdata = {24'd0, r_cfg.delim};
            default:        prdata = '0;
        endcase
    end

    // front: framing and cobs group tracking, one byte per cycle while the queue has room
    cfd_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_rx_byte   (s_axis_tdata),
        .i_line_idle (s_axis_tuser),
        .i_cfg       (r_cfg),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_res       (w_push_res)
    );

    // queue decouples the front from output backpressure
    cfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_res),
        .i_pop   (w_pop),
        .o_rdata (w_pop_res),
        .o_stat  (w_qstat)
    );

    // back: output register toward the result stream
    cfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (w_qstat),
        .i_rdata (w_pop_res),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_out_res)
    );

    assign m_axis_tdata = {4'd0, w_out_res.frame_length, w_out_res.frame_status,
                           w_out_res.out_byte};
    assign m_axis_tuser = w_out_res.has_byte;
    assign m_axis_tlast = w_out_res.frame_end;

    // no push into a full queue, no pop from an empty one
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("push into full queue");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("pop from empty queue");

    // a frame-end result never carries a byte
    a_end_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tuser)
        else $error("frame end with data byte");

    // error frames report zero length
    a_err_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast && (w_out_res.frame_status != ST_OK))
        |-> (w_out_res.frame_length == '0))
        else $error("error frame with nonzero length");

endmodule
